/* rtl/core/bet_pkg.sv */
// Package for the breakpoint envelope table: constants, opcodes, FSM states
// and the transaction structs of the item channels. No dependencies.
package bet_pkg;

    localparam int KEYS_DEF     = 16;
    localparam int CHANNELS_DEF = 4;
    localparam int CH_W         = 2;
    localparam int VAL_W        = 16;
    localparam int ENT_W        = 2 * VAL_W;

    localparam logic signed [VAL_W-1:0] VAL_MAX       = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN       = 16'sh8000;
    localparam logic        [3:0]       CHAN_MASK_ALL = 4'hF;

    typedef enum logic [2:0] {
        OP_SET_POS  = 3'd0,
        OP_KEY_MASK = 3'd1,
        OP_DEL_MASK = 3'd2,
        OP_CLR_MASK = 3'd3,
        OP_SET_IN   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_WRAP_EN  = 2'd0,
        CFG_CLIP_EN  = 2'd1,
        CFG_CLIP_LOW = 2'd2,
        CFG_CLIP_HIGH = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEXT,
        S_SCAN0,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_DIVEND,
        S_POST,
        S_SHU_RD,
        S_SHU_WR,
        S_SHD_RD,
        S_SHD_WR,
        S_WNEW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [3:0]              channel_mask;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out_item;

endpackage

/* rtl/core/bet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/breakpoint_envelope_table.sv */
// Breakpoint envelope table top level: sequencer, table walk, shared divider.
// Depends on bet_pkg and bet_ram. One transaction at a time.
// Per reported channel: control states, a table walk reading each stored breakpoint,
// multiply and 32-step divide when interpolating; insert adds a write and a read and
// write per moved entry, delete a read and write per moved entry and a second walk.
// Synchronous active-low reset clears control state, counts, masks, position, registers.
module breakpoint_envelope_table
    import bet_pkg::*;
#(
    parameter int KEYS     = KEYS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [VAL_W-1:0] i_cfg_data
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int NW = $clog2(KEYS + 1);
    localparam int AW = CH_W + KW;

    typedef logic signed [VAL_W-1:0] t_val;

    t_state r_state, n_state;

    // configuration
    logic r_wrap_en, r_clip_en;
    t_val r_clip_low, r_clip_high;

    // per-transaction control
    logic [2:0]          r_op;
    logic [CHANNELS-1:0] r_mask;
    logic [CHANNELS-1:0] r_key_mask;
    logic [CH_W-1:0]     r_ch;
    t_val                r_pos;
    logic                r_del_done;
    logic                r_ins;
    t_val                r_res;
    logic [NW-1:0]       r_count [CHANNELS];
    t_val                r_chan_in [CHANNELS];

    // table walk trackers
    logic [NW-1:0] r_k, r_at;
    logic          r_lo_vld, r_hi_vld;
    logic [NW-1:0] r_lo_idx;
    t_val          r_lo_pos, r_lo_val, r_hi_pos, r_hi_val;
    t_val          r_first_pos, r_first_val, r_last_pos, r_last_val;

    // interpolation / divider
    t_val                r_v1;
    logic signed [VAL_W:0] r_diff;
    logic [VAL_W-1:0]    r_d, r_span;
    logic                r_neg;
    logic [31:0]         r_quo;
    logic [VAL_W-1:0]    r_rem;
    logic [5:0]          r_dcnt;

    // RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    t_val             rd_pos, rd_val;

    bet_ram #(
        .WIDTH (ENT_W),
        .DEPTH (1 << AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pos = ram_rdata[ENT_W-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    logic [NW-1:0] cur_n;
    assign cur_n = r_count[r_ch];

    // mask of the incoming transaction
    logic [CHANNELS-1:0] in_mask;
    logic [CHANNELS-1:0] in_sel;
    always_comb begin
        in_mask = i_in_data.channel_mask[CHANNELS-1:0];
        in_sel  = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_in_data.channel == CH_W'(c)) begin
                in_sel[c] = 1'b1;
            end
        end
    end

    // nearest breakpoint index from the walk trackers
    logic [NW-1:0]         near_idx;
    logic signed [VAL_W:0] dist_hi, dist_lo;
    always_comb begin
        dist_hi = {r_hi_pos[VAL_W-1], r_hi_pos} - {r_pos[VAL_W-1], r_pos};
        dist_lo = {r_pos[VAL_W-1], r_pos} - {r_lo_pos[VAL_W-1], r_lo_pos};
        if (!r_lo_vld) begin
            near_idx = '0;
        end else if (!r_hi_vld) begin
            near_idx = r_lo_idx;
        end else if (dist_hi < dist_lo) begin
            near_idx = r_lo_idx + NW'(1);
        end else begin
            near_idx = r_lo_idx;
        end
    end

    // segment selection for interpolation
    logic  ip_direct;
    t_val  ip_dval, ip_p1, ip_v1, ip_p2, ip_v2;
    logic [VAL_W-1:0] ip_d, ip_span;
    always_comb begin
        ip_direct = 1'b0;
        ip_dval   = '0;
        ip_p1     = r_lo_pos;
        ip_v1     = r_lo_val;
        ip_p2     = r_hi_pos;
        ip_v2     = r_hi_val;
        if (cur_n == '0) begin
            ip_direct = 1'b1;
        end else if (!r_lo_vld) begin
            if (!r_wrap_en) begin
                ip_direct = 1'b1;
                ip_dval   = r_first_val;
            end else begin
                ip_p1 = r_last_pos;
                ip_v1 = r_last_val;
                ip_p2 = r_first_pos;
                ip_v2 = r_first_val;
            end
        end else if (!r_hi_vld) begin
            if (!r_wrap_en) begin
                ip_direct = 1'b1;
                ip_dval   = r_lo_val;
            end else begin
                ip_p2 = r_first_pos;
                ip_v2 = r_first_val;
            end
        end
        ip_d    = r_pos - ip_p1;
        ip_span = ip_p2 - ip_p1;
        if (!ip_direct) begin
            if (ip_span == '0) begin
                ip_direct = 1'b1;
                ip_dval   = ip_v1;
            end else if (ip_d >= ip_span) begin
                ip_direct = 1'b1;
                ip_dval   = ip_v2;
            end
        end
    end

    // saturating add of the channel input to an existing breakpoint
    logic signed [VAL_W:0] sat_sum;
    t_val                  sat_val;
    logic                  key_eq;
    always_comb begin
        sat_sum = {r_lo_val[VAL_W-1], r_lo_val}
                + {r_chan_in[r_ch][VAL_W-1], r_chan_in[r_ch]};
        // top two bits differ on overflow; the top bit gives the direction
        if (sat_sum[VAL_W] != sat_sum[VAL_W-1]) begin
            sat_val = sat_sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            sat_val = sat_sum[VAL_W-1:0];
        end
        key_eq = r_lo_vld && (r_lo_pos == r_pos);
    end

    logic is_key;
    assign is_key = (r_op == OP_KEY_MASK) || (r_op == OP_SET_IN);

    // multiply and divider step
    logic signed [33:0] mul_res;
    logic [33:0]        mul_abs;
    logic [VAL_W:0]     div_t;
    assign mul_res = r_diff * $signed({1'b0, r_d});
    assign mul_abs = mul_res[33] ? -mul_res : mul_res;
    assign div_t   = {r_rem, r_quo[31]};

    logic signed [VAL_W+1:0] div_out;
    assign div_out = r_neg ? ({{2{r_v1[VAL_W-1]}}, r_v1} - {2'b00, r_quo[VAL_W-1:0]})
                           : ({{2{r_v1[VAL_W-1]}}, r_v1} + {2'b00, r_quo[VAL_W-1:0]});

    // lowest pending channel
    logic [CH_W-1:0]     pick_ch;
    logic [CHANNELS-1:0] pick_clr;
    always_comb begin
        pick_ch  = '0;
        pick_clr = r_mask;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                pick_ch = CH_W'(c);
            end
        end
        pick_clr[pick_ch] = 1'b0;
    end

    // next state and RAM port control
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = {r_ch, r_k[KW-1:0]};
        ram_wdata = {r_pos, r_res};
        ram_raddr = {r_ch, r_k[KW-1:0]};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.opcode)
                        OP_SET_POS: n_state = S_NEXT;
                        OP_KEY_MASK, OP_DEL_MASK: begin
                            if (in_mask != '0) begin
                                n_state = S_NEXT;
                            end
                        end
                        OP_SET_IN: begin
                            if ((in_sel & r_key_mask) != '0) begin
                                n_state = S_NEXT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_NEXT:     n_state = (r_mask == '0) ? S_IDLE : S_SCAN0;
            S_SCAN0:    n_state = (cur_n == '0) ? S_EVAL : S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: n_state = (r_k + NW'(1) == cur_n) ? S_EVAL : S_SCAN_RD;
            S_EVAL: begin
                if (is_key && cur_n == '0) begin
                    n_state = S_WNEW;
                end else if (is_key && key_eq) begin
                    n_state = S_WNEW;
                end else if (r_op == OP_DEL_MASK && !r_del_done) begin
                    if (cur_n == '0) begin
                        n_state = S_OUT;
                    end else if (near_idx + NW'(1) < cur_n) begin
                        n_state = S_SHD_RD;
                    end else begin
                        n_state = S_SCAN0;
                    end
                end else if (ip_direct) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DIV;
            S_DIV:    n_state = (r_dcnt == 6'd31) ? S_DIVEND : S_DIV;
            S_DIVEND: n_state = S_POST;
            S_POST: begin
                if (!is_key) begin
                    n_state = S_OUT;
                end else if (cur_n >= NW'(KEYS)) begin
                    n_state = S_WNEW;
                end else if (cur_n > (r_lo_vld ? r_lo_idx + NW'(1) : NW'(0))) begin
                    n_state = S_SHU_RD;
                end else begin
                    n_state = S_WNEW;
                end
            end
            S_SHU_RD: begin
                ram_raddr = {r_ch, KW'(r_k - NW'(1))};
                n_state   = S_SHU_WR;
            end
            S_SHU_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_state   = (r_k - NW'(1) > r_at) ? S_SHU_RD : S_WNEW;
            end
            S_SHD_RD: begin
                ram_raddr = {r_ch, KW'(r_k + NW'(1))};
                n_state   = S_SHD_WR;
            end
            S_SHD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_state   = (r_k + NW'(2) < cur_n) ? S_SHD_RD : S_SCAN0;
            end
            S_WNEW: begin
                ram_we  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = (r_mask == '0) ? S_IDLE : S_NEXT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_en   <= 1'b0;
            r_clip_en   <= 1'b0;
            r_clip_low  <= VAL_MIN;
            r_clip_high <= VAL_MAX;
            r_key_mask  <= '0;
            r_mask      <= '0;
            r_del_done  <= 1'b0;
            r_op        <= '0;
            r_pos       <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c]   <= '0;
                r_chan_in[c] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WRAP_EN:   r_wrap_en   <= i_cfg_data[0];
                    CFG_CLIP_EN:   r_clip_en   <= i_cfg_data[0];
                    CFG_CLIP_LOW:  r_clip_low  <= i_cfg_data;
                    CFG_CLIP_HIGH: r_clip_high <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op <= i_in_data.opcode;
                        case (i_in_data.opcode)
                            OP_SET_POS: begin
                                r_mask <= '1;
                                r_pos  <= i_in_data.value;
                            end
                            OP_KEY_MASK: begin
                                r_key_mask <= in_mask;
                                r_mask     <= in_mask;
                            end
                            OP_DEL_MASK: r_mask <= in_mask;
                            OP_CLR_MASK: begin
                                for (int c = 0; c < CHANNELS; c++) begin
                                    if (in_mask[c]) begin
                                        r_count[c] <= '0;
                                    end
                                end
                            end
                            OP_SET_IN: begin
                                r_mask <= in_sel & r_key_mask;
                                for (int c = 0; c < CHANNELS; c++) begin
                                    if (in_sel[c]) begin
                                        r_chan_in[c] <= i_in_data.value;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_NEXT: begin
                    r_mask     <= pick_clr;
                    r_del_done <= 1'b0;
                end
                S_EVAL: begin
                    if (r_op == OP_DEL_MASK && !r_del_done && !(is_key)) begin
                        if (cur_n != '0 && !(near_idx + NW'(1) < cur_n)) begin
                            r_count[r_ch] <= cur_n - NW'(1);
                        end
                        r_del_done <= 1'b1;
                    end
                end
                S_SHD_WR: begin
                    if (!(r_k + NW'(2) < cur_n)) begin
                        r_count[r_ch] <= cur_n - NW'(1);
                    end
                end
                S_WNEW: begin
                    if (r_ins) begin
                        r_count[r_ch] <= cur_n + NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_NEXT: r_ch <= pick_ch;
            S_SCAN0: begin
                r_k      <= '0;
                r_lo_vld <= 1'b0;
                r_hi_vld <= 1'b0;
            end
            S_SCAN_CHK: begin
                if (r_k == '0) begin
                    r_first_pos <= rd_pos;
                    r_first_val <= rd_val;
                end
                r_last_pos <= rd_pos;
                r_last_val <= rd_val;
                if (rd_pos <= r_pos) begin
                    r_lo_vld <= 1'b1;
                    r_lo_idx <= r_k;
                    r_lo_pos <= rd_pos;
                    r_lo_val <= rd_val;
                end else if (!r_hi_vld) begin
                    r_hi_vld <= 1'b1;
                    r_hi_pos <= rd_pos;
                    r_hi_val <= rd_val;
                end
                r_k <= r_k + NW'(1);
            end
            S_EVAL: begin
                r_v1   <= ip_v1;
                r_diff <= {ip_v2[VAL_W-1], ip_v2} - {ip_v1[VAL_W-1], ip_v1};
                r_d    <= ip_d;
                r_span <= ip_span;
                if (is_key && cur_n == '0) begin
                    r_res <= r_chan_in[r_ch];
                    r_k   <= '0;
                    r_ins <= 1'b1;
                end else if (is_key && key_eq) begin
                    r_res <= sat_val;
                    r_k   <= r_lo_idx;
                    r_ins <= 1'b0;
                end else if (r_op == OP_DEL_MASK && !r_del_done) begin
                    r_res <= '0;
                    r_k   <= near_idx;
                end else begin
                    r_res <= ip_dval;
                end
            end
            S_MUL: begin
                r_neg  <= mul_res[33];
                r_quo  <= mul_abs[31:0];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                if (div_t >= {1'b0, r_span}) begin
                    r_rem <= VAL_W'(div_t - {1'b0, r_span});
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= div_t[VAL_W-1:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 6'd1;
            end
            S_DIVEND: r_res <= div_out[VAL_W-1:0];
            S_POST: begin
                if (r_op == OP_SET_POS && r_clip_en) begin
                    if (r_res < r_clip_low) begin
                        r_res <= r_clip_low;
                    end else if (r_res > r_clip_high) begin
                        r_res <= r_clip_high;
                    end
                end
                if (cur_n >= NW'(KEYS)) begin
                    r_k   <= near_idx;
                    r_ins <= 1'b0;
                end else begin
                    r_at  <= r_lo_vld ? r_lo_idx + NW'(1) : NW'(0);
                    r_ins <= 1'b1;
                    if (cur_n > (r_lo_vld ? r_lo_idx + NW'(1) : NW'(0))) begin
                        r_k <= cur_n;
                    end else begin
                        r_k <= r_lo_vld ? r_lo_idx + NW'(1) : NW'(0);
                    end
                end
            end
            S_SHU_WR: r_k <= r_k - NW'(1);
            S_SHD_WR: r_k <= r_k + NW'(1);
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = '{out_channel: r_ch, out_value: r_res, last: (r_mask == '0)};

endmodule

/* sim/tb.sv */
// Self-checking testbench for breakpoint_envelope_table: predicts every result
// transaction and compares them in order. Depends on bet_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import bet_pkg::*;

    localparam int NCH      = CHANNELS_DEF;
    localparam int NKEYS    = KEYS_DEF;
    localparam int SETTLE   = 600;   // worst item: 4 channels x (walk + divide + shift)
    localparam int DRAIN_MAX = 200000;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    t_in_item        i_in_data;
    logic            o_out_valid;
    logic            i_out_stall;
    t_out_item       o_out_data;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_index;
    logic [VAL_W-1:0] i_cfg_data;

    breakpoint_envelope_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Envelope state mirror
    logic signed [15:0] brk_pos [NCH][NKEYS];
    logic signed [15:0] brk_val [NCH][NKEYS];
    int          brk_cnt [NCH];
    int          cur_pos;
    int          chan_in [NCH];
    logic [3:0]  keyed_chans;
    bit          wrap_on, clip_on;
    int          clip_lo, clip_hi;

    t_out_item   env_expect_q[$];
    int          err_count;
    int          items_sent, results_seen, cfg_writes;
    int          send_idle_pct, stall_pct, stall_hold;

    function automatic void env_clear(int c);
        for (int k = 0; k < NKEYS; k++) begin
            brk_pos[c][k] = VAL_MAX;
            brk_val[c][k] = '0;
        end
        brk_cnt[c] = 0;
    endfunction

    function automatic int below_idx(int c, int pos);
        int i;
        i = -1;
        for (int k = 0; k < brk_cnt[c]; k++)
            if (int'(brk_pos[c][k]) <= pos) i = k;
        return i;
    endfunction

    // nearest breakpoint, ties to the lower one
    function automatic int near_idx(int c, int pos);
        int lo;
        lo = below_idx(c, pos);
        if (lo < 0) return 0;
        if (lo >= brk_cnt[c] - 1) return lo;
        if (int'(brk_pos[c][lo+1]) - pos < pos - int'(brk_pos[c][lo])) return lo + 1;
        return lo;
    endfunction

    function automatic int env_interp(int c, int pos);
        int n, lo, hi, p1, v1, p2, v2, d, span;
        longint prod;
        n = brk_cnt[c];
        if (n == 0) return 0;
        lo = below_idx(c, pos);
        if (lo < 0) begin
            if (!wrap_on) return brk_val[c][0];
            lo = n - 1;
        end
        hi = lo + 1;
        if (hi >= n) begin
            if (!wrap_on) return brk_val[c][n-1];
            hi = 0;
        end
        p1 = brk_pos[c][lo]; v1 = brk_val[c][lo];
        p2 = brk_pos[c][hi]; v2 = brk_val[c][hi];
        d    = (pos - p1) & 32'hFFFF;
        span = (p2 - p1) & 32'hFFFF;
        if (span == 0) return v1;
        if (d >= span) return v2;
        prod = longint'(v2 - v1) * longint'(d);
        return v1 + int'(prod / longint'(span));
    endfunction

    function automatic void env_insert(int c, int at, int pos, int v);
        for (int k = brk_cnt[c]; k > at; k--) begin
            brk_pos[c][k] = brk_pos[c][k-1];
            brk_val[c][k] = brk_val[c][k-1];
        end
        brk_pos[c][at] = pos[15:0];
        brk_val[c][at] = v[15:0];
        brk_cnt[c]++;
    endfunction

    function automatic int env_key(int c);
        int idx, v;
        if (brk_cnt[c] == 0) begin
            env_insert(c, 0, cur_pos, chan_in[c]);
            return chan_in[c];
        end
        idx = near_idx(c, cur_pos);
        if (int'(brk_pos[c][idx]) == cur_pos) begin
            // saturating add onto the existing breakpoint
            v = int'(brk_val[c][idx]) + chan_in[c];
            if (v > int'(VAL_MAX)) v = VAL_MAX;
            if (v < int'(VAL_MIN)) v = VAL_MIN;
            brk_val[c][idx] = v[15:0];
            return v;
        end
        v = env_interp(c, cur_pos);
        if (brk_cnt[c] >= NKEYS) begin
            brk_pos[c][idx] = cur_pos[15:0];
            brk_val[c][idx] = v[15:0];
        end else begin
            env_insert(c, below_idx(c, cur_pos) + 1, cur_pos, v);
        end
        return v;
    endfunction

    function automatic void env_delete(int c);
        int idx, n;
        n = brk_cnt[c];
        if (n == 0) return;
        idx = near_idx(c, cur_pos);
        for (int k = idx; k < n - 1; k++) begin
            brk_pos[c][k] = brk_pos[c][k+1];
            brk_val[c][k] = brk_val[c][k+1];
        end
        brk_pos[c][n-1] = VAL_MAX;
        brk_val[c][n-1] = '0;
        brk_cnt[c] = n - 1;
    endfunction

    function automatic int env_clip(int v);
        if (v < clip_lo) return clip_lo;
        if (v > clip_hi) return clip_hi;
        return v;
    endfunction

    // Work out the results of one accepted transaction and queue them
    function automatic void env_predict(t_in_item it);
        t_out_item res[$];
        t_out_item r;
        int v, val;
        val = int'(it.value);
        case (it.opcode)
            OP_SET_POS: begin
                cur_pos = val;
                for (int c = 0; c < NCH; c++) begin
                    v = env_interp(c, cur_pos);
                    if (clip_on) v = env_clip(v);
                    r = '{out_channel: c[1:0], out_value: v[15:0], last: 1'b0};
                    res.push_back(r);
                end
            end
            OP_KEY_MASK: begin
                keyed_chans = it.channel_mask;
                for (int c = 0; c < NCH; c++)
                    if (keyed_chans[c]) begin
                        v = env_key(c);
                        r = '{out_channel: c[1:0], out_value: v[15:0], last: 1'b0};
                        res.push_back(r);
                    end
            end
            OP_DEL_MASK: begin
                for (int c = 0; c < NCH; c++)
                    if (it.channel_mask[c]) begin
                        env_delete(c);
                        v = env_interp(c, cur_pos);
                        r = '{out_channel: c[1:0], out_value: v[15:0], last: 1'b0};
                        res.push_back(r);
                    end
            end
            OP_CLR_MASK: begin
                for (int c = 0; c < NCH; c++)
                    if (it.channel_mask[c]) env_clear(c);
            end
            OP_SET_IN: begin
                chan_in[it.channel] = val;
                if (keyed_chans[it.channel]) begin
                    v = env_key(it.channel);
                    r = '{out_channel: it.channel, out_value: v[15:0], last: 1'b0};
                    res.push_back(r);
                end
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) env_expect_q.push_back(res[i]);
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (env_expect_q.size() == 0) begin
                $display("%0t: unexpected result ch=%0d val=%0d last=%0b", $time,
                         o_out_data.out_channel, o_out_data.out_value, o_out_data.last);
                err_count++;
            end else begin
                t_out_item e;
                e = env_expect_q.pop_front();
                if (e.out_channel !== o_out_data.out_channel)
                    begin $display("%0t: out_channel exp %0d got %0d", $time,
                                   e.out_channel, o_out_data.out_channel); err_count++; end
                if (e.out_value !== o_out_data.out_value)
                    begin $display("%0t: out_value (ch %0d) exp %0d got %0d", $time,
                                   e.out_channel, e.out_value, o_out_data.out_value);
                          err_count++; end
                if (e.last !== o_out_data.last)
                    begin $display("%0t: last exp %0b got %0b", $time,
                                   e.last, o_out_data.last); err_count++; end
            end
        end
    end

    // Receiver stall: random by percentage, or a long counted hold-off
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= stall_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offer one transaction, hold it until accepted, then maybe go idle
    task automatic send_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        env_predict(it);
        if (it.opcode <= OP_SET_IN) items_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_op(t_opcode op, logic [3:0] msk, logic [1:0] ch, int val);
        t_in_item it;
        it.opcode = op; it.channel_mask = msk; it.channel = ch; it.value = val[15:0];
        send_item(it);
    endtask

    // Lower valid, wait for all expected results, then let the block settle
    task automatic drain();
        int waited;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (env_expect_q.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WRAP_EN:   wrap_on = data[0];
            CFG_CLIP_EN:   clip_on = data[0];
            CFG_CLIP_LOW:  clip_lo = int'($signed(data[15:0]));
            CFG_CLIP_HIGH: clip_hi = int'($signed(data[15:0]));
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(bit wr, bit ce, int lo, int hi);
        drain();
        cfg_write(CFG_WRAP_EN, wr);
        cfg_write(CFG_CLIP_EN, ce);
        cfg_write(CFG_CLIP_LOW, lo);
        cfg_write(CFG_CLIP_HIGH, hi);
    endtask

    // Positions mostly from a small set so keys land on existing breakpoints
    function automatic int pick_pos();
        int pool[8] = '{-32768, -1000, -5, 0, 7, 300, 12000, 32767};
        if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 7)];
        return int'($signed(16'($urandom)));
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int r;
        it.opcode = OP_SET_POS;
        it.channel_mask = 4'($urandom);
        it.channel = 2'($urandom);
        it.value = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 28) begin
            it.value = 16'(pick_pos());
        end else if (r < 50) begin
            it.opcode = OP_SET_IN;
            if ($urandom_range(0, 1)) it.value = 16'($signed($urandom_range(0, 400)) - 200);
        end else if (r < 68) begin
            it.opcode = OP_KEY_MASK;
        end else if (r < 80) begin
            it.opcode = OP_DEL_MASK;
        end else if (r < 84) begin
            it.opcode = OP_CLR_MASK;
        end else if (r < 89) begin
            it.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return it;
    endfunction

    task automatic run_random(int n);
        t_in_item it;
        int done;
        done = 0;
        while (done < n) begin
            it = rand_item();
            send_item(it);
            if (it.opcode <= OP_SET_IN) done++;
        end
    endtask

    // Extremes, every opcode, saturation, full table, unused opcodes
    task automatic test_directed();
        send_op(OP_SET_POS, 4'h0, 2'd0, 0);              // empty tables report zero
        send_op(OP_KEY_MASK, 4'h0, 2'd0, 0);             // zero mask, no results
        send_op(OP_SET_IN, 4'h0, 2'd0, 32767);
        send_op(OP_SET_IN, 4'h0, 2'd1, -32768);
        send_op(OP_SET_IN, 4'h0, 2'd2, 100);
        send_op(OP_SET_IN, 4'h0, 2'd3, -1);
        send_op(OP_KEY_MASK, CHAN_MASK_ALL, 2'd0, 0);    // insert into empty tables
        send_op(OP_KEY_MASK, CHAN_MASK_ALL, 2'd0, 0);    // add at existing, saturates
        send_op(OP_SET_POS, 4'h0, 2'd0, -32768);
        send_op(OP_SET_IN, 4'h0, 2'd0, 5);               // keyed channel inserts
        send_op(OP_SET_POS, 4'h0, 2'd0, 32767);
        send_op(OP_SET_IN, 4'h0, 2'd2, -32768);
        send_op(OP_SET_POS, 4'h0, 2'd0, 16000);          // interpolate between ends
        send_op(OP_DEL_MASK, 4'b0101, 2'd0, 0);
        send_op(OP_DEL_MASK, CHAN_MASK_ALL, 2'd0, 0);
        send_op(OP_CLR_MASK, 4'b1010, 2'd0, 0);
        send_op(OP_DEL_MASK, 4'b1010, 2'd0, 0);          // delete on empty table
        send_op(t_opcode'(OP_UNUSED_LO), CHAN_MASK_ALL, 2'd3, -1);
        send_op(t_opcode'(OP_UNUSED_HI), CHAN_MASK_ALL, 2'd3, -1);
        // fill channel 0 past its capacity so keys replace the nearest entry
        send_op(OP_KEY_MASK, 4'b0001, 2'd0, 0);
        for (int k = 0; k < NKEYS + 3; k++) begin
            send_op(OP_SET_POS, 4'h0, 2'd0, -30000 + k * 3001);
            send_op(OP_SET_IN, 4'h0, 2'd0, k * 997 - 9000);
        end
        send_op(OP_KEY_MASK, 4'h0, 2'd0, 0);
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        stall_pct     = stall;
        run_random(n);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Long receiver hold-off while the sender keeps offering transactions
    task automatic test_backpressure();
        stall_pct  = 0;
        stall_hold = 400;
        send_op(OP_KEY_MASK, CHAN_MASK_ALL, 2'd0, 0);
        for (int k = 0; k < 8; k++) send_op(OP_SET_POS, 4'h0, 2'd0, pick_pos());
    endtask

    // Run limit
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WRAP_EN;
        i_cfg_data = '0;
        err_count = 0; items_sent = 0; results_seen = 0; cfg_writes = 0;
        send_idle_pct = 0; stall_pct = 0; stall_hold = 0;
        for (int c = 0; c < NCH; c++) begin
            env_clear(c);
            chan_in[c] = 0;
        end
        cur_pos = 0; keyed_chans = '0;
        wrap_on = 0; clip_on = 0; clip_lo = VAL_MIN; clip_hi = VAL_MAX;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_config(1'b1, 1'b1, -32768, 32767);
        test_random_phase(0, 0, 50);
        set_config(1'b1, 1'b1, -200, 5000);
        test_random_phase(48, 0, 45);
        set_config(1'b0, 1'b1, 100, -100);               // inverted clip bounds
        test_random_phase(0, 48, 45);
        set_config(1'b1, 1'b0, -32767, 32766);
        test_random_phase(16, 16, 45);
        set_config(1'b0, 1'b1, 32766, -32767);
        test_backpressure();
        drain();

        $display("covered %0d transactions, %0d results, %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with wrap and clipping on and off, inverted bounds and long hold-offs");
        if (err_count == 0 && env_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (env_expect_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, env_expect_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
